// ----- hdl/bmphdr_pkg.sv -----
// Package for the BMP header checker and pixel address block.
// Holds the transaction types, command and status codes and header layout constants.
// Depends on nothing.
package bmphdr_pkg;

  localparam int unsigned HDR_LEN      = 54;
  localparam int unsigned HDR_CNT_W    = 6;
  localparam int unsigned FILE_HDR_LEN = 14;
  localparam int unsigned INFO_HDR_LEN = 40;

  localparam int unsigned OFS_SIG    = 0;
  localparam int unsigned OFS_DECL   = 2;
  localparam int unsigned OFS_OFFSET = 10;
  localparam int unsigned OFS_DIB    = 14;
  localparam int unsigned OFS_WIDTH  = 18;
  localparam int unsigned OFS_HEIGHT = 22;
  localparam int unsigned OFS_PLANES = 26;
  localparam int unsigned OFS_DEPTH  = 28;
  localparam int unsigned OFS_COMP   = 30;

  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [15:0] PLANES_OK  = 16'd1;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [31:0] COMP_NONE  = 32'd0;
  localparam logic [31:0] HEIGHT_MIN = 32'h8000_0000;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_PACK   = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BUF_SHORT   = 4'd1;
  localparam logic [3:0] ST_BAD_SIG     = 4'd2;
  localparam logic [3:0] ST_BAD_SIZES   = 4'd3;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd4;
  localparam logic [3:0] ST_STRIDE_OVF  = 4'd5;
  localparam logic [3:0] ST_PIX_EXCEED  = 4'd6;
  localparam logic [3:0] ST_NO_IMAGE    = 4'd7;
  localparam logic [3:0] ST_OUT_RANGE   = 4'd8;
  localparam logic [3:0] ST_BEYOND_DATA = 4'd9;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] rgb_bytes;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [31:0] data_start;
    logic [31:0] stride_bytes;
    logic        is_top_first;
    logic [31:0] byte_address;
    logic [31:0] color;
  } out_item_t;

  typedef struct packed {
    logic [30:0] width;
    logic [30:0] height;
    logic [31:0] start;
    logic [31:0] stride;
    logic        top_first;
  } geom_t;

  typedef struct packed {
    logic first;
    logic last;
  } hdr_evt_t;

  typedef struct packed {
    logic [3:0]  status;
    geom_t       geom;
    logic [31:0] file_size;
  } hdr_res_t;

endpackage

// ----- hdl/bmp_header_check_and_pixel_address.sv -----
// Top level of the BMP 24-bit header checker and pixel address generator.
// Holds the stored image, the four-stage result pipeline and the config register.
// Depends on bmphdr_pkg and bmphdr_hdr_check.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one transaction per cycle while in_stall_o is low.
//   Command 0 carries a header byte; the 54th byte of a header gives one result with
//   the check status and geometry, the other header bytes give none. Command 1 looks up
//   the blue-byte address of pixel x,y; command 2 packs three bytes into 0xFFRRGGBB.
//   Command 3 is dropped with no result.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns results in order.
//   A result passes through the input register and then the row times stride multiply,
//   address add and bound check stages before it is presented.
//   Throughput: one item per cycle while out_stall_i is low.
//   A stalled output holds its transaction; upstream stages keep filling empty slots
//   and in_stall_o rises only once all four stages hold results.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes buffer_size;
//   ready is always high. Write it only while the block is idle.
//   Reset clears the byte count, the stored image, buffer_size and the pipeline.
module bmp_header_check_and_pixel_address import bmphdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  typedef struct packed {
    logic [3:0]  status;
    logic        chk;
    geom_t       geom;
    logic [31:0] fsize;
    logic [30:0] row;
    logic [30:0] x;
    logic [31:0] color;
  } s1_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        chk;
    geom_t       geom;
    logic [31:0] fsize;
    logic [62:0] prod;
    logic [32:0] x3;
    logic [31:0] color;
  } s2_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        chk;
    geom_t       geom;
    logic [31:0] fsize;
    logic [63:0] sum;
    logic [31:0] color;
  } s3_t;

  logic [31:0] buffer_size_q;

  logic        have_q, have_d;
  geom_t       geom_q, geom_d;
  logic [31:0] fsize_q, fsize_d;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        ld1, ld2, ld3, ld4;
  s1_t         s1_q, s1_d;
  s2_t         s2_q;
  s3_t         s3_q;
  out_item_t   s4_q, s4_d;

  logic        accept;
  logic        hdr_byte;
  logic        has_result;
  logic        in_range;
  logic [64:0] end_addr;
  logic        over;
  hdr_evt_t    evt;
  hdr_res_t    hres;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= '0;
    end else if (cfg_valid_i) begin
      buffer_size_q <= cfg_data_i;
    end
  end

  assign ld4        = !v4_q || !out_stall_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_stall_o = !ld1;
  assign accept     = in_valid_i && ld1;
  assign hdr_byte   = accept && (in_data_i.command == CMD_HEADER);

  bmphdr_hdr_check u_hdr_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (hdr_byte),
    .byte_i        (in_data_i.data_byte),
    .buffer_size_i (buffer_size_q),
    .evt_o         (evt),
    .res_o         (hres)
  );

  always_comb begin
    have_d  = have_q;
    geom_d  = geom_q;
    fsize_d = fsize_q;
    if (hdr_byte && evt.first) begin
      have_d  = 1'b0;
      geom_d  = '0;
      fsize_d = '0;
    end else if (hdr_byte && evt.last && (hres.status == ST_OK)) begin
      have_d  = 1'b1;
      geom_d  = hres.geom;
      fsize_d = hres.file_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      geom_q  <= '0;
      fsize_q <= '0;
    end else begin
      have_q  <= have_d;
      geom_q  <= geom_d;
      fsize_q <= fsize_d;
    end
  end

  assign in_range = (in_data_i.x < {1'b0, geom_q.width}) &&
                    (in_data_i.y < {1'b0, geom_q.height});

  always_comb begin
    s1_d        = '0;
    s1_d.geom   = geom_d;
    s1_d.fsize  = fsize_d;
    s1_d.x      = in_data_i.x[30:0];
    s1_d.row    = geom_q.top_first ? in_data_i.y[30:0]
                                   : geom_q.height - 31'd1 - in_data_i.y[30:0];
    has_result  = 1'b0;
    unique case (in_data_i.command)
      CMD_HEADER: begin
        has_result  = evt.last;
        s1_d.status = hres.status;
      end
      CMD_LOOKUP: begin
        has_result = 1'b1;
        priority if (!have_q) begin
          s1_d.status = ST_NO_IMAGE;
        end else if (!in_range) begin
          s1_d.status = ST_OUT_RANGE;
        end else begin
          s1_d.status = ST_OK;
          s1_d.chk    = 1'b1;
        end
      end
      CMD_PACK: begin
        has_result  = 1'b1;
        s1_d.status = ST_OK;
        s1_d.color  = {ALPHA_FULL, in_data_i.rgb_bytes};
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign end_addr = 65'(s3_q.sum) + 65'd3;
  assign over     = end_addr > 65'(s3_q.fsize);

  always_comb begin
    s4_d              = '0;
    s4_d.image_width  = s3_q.geom.width;
    s4_d.image_height = s3_q.geom.height;
    s4_d.data_start   = s3_q.geom.start;
    s4_d.stride_bytes = s3_q.geom.stride;
    s4_d.is_top_first = s3_q.geom.top_first;
    s4_d.color        = s3_q.color;
    s4_d.status       = s3_q.status;
    if (s3_q.chk) begin
      if (over) begin
        s4_d.status = ST_BEYOND_DATA;
      end else begin
        s4_d.byte_address = s3_q.sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= accept && has_result;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_q <= s1_d;
    end
    if (ld2) begin
      s2_q.status <= s1_q.status;
      s2_q.chk    <= s1_q.chk;
      s2_q.geom   <= s1_q.geom;
      s2_q.fsize  <= s1_q.fsize;
      s2_q.color  <= s1_q.color;
      s2_q.prod   <= 63'(s1_q.row) * 63'(s1_q.geom.stride);
      s2_q.x3     <= {2'b00, s1_q.x} + {1'b0, s1_q.x, 1'b0};
    end
    if (ld3) begin
      s3_q.status <= s2_q.status;
      s3_q.chk    <= s2_q.chk;
      s3_q.geom   <= s2_q.geom;
      s3_q.fsize  <= s2_q.fsize;
      s3_q.color  <= s2_q.color;
      s3_q.sum    <= 64'(s2_q.geom.start) + 64'(s2_q.prod) + 64'(s2_q.x3);
    end
    if (ld4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = s4_q;

endmodule

// ----- hdl/bmphdr_hdr_check.sv -----
// Header byte capture and check for the BMP header checker.
// Collects header fields by byte position and precomputes the size checks.
// Depends on bmphdr_pkg.
module bmphdr_hdr_check import bmphdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] buffer_size_i,
  output hdr_evt_t    evt_o,
  output hdr_res_t    res_o
);

  logic [HDR_CNT_W-1:0] count_q, count_d;

  logic [7:0]  sig0_q, sig1_q;
  logic [31:0] decl_q, offset_q, dib_q, width_q, height_q, comp_q;
  logic [15:0] planes_q, depth_q;

  logic [32:0] hdr_end_q;
  logic [33:0] stride_q;
  logic [31:0] abs_h_q;
  logic        sig_bad_q, decl_short_q, dib_short_q, geo_bad_q, fmt_bad_q;
  logic        end_bad_q, stride_ovf_q;
  logic [63:0] prod_q;
  logic [64:0] need_q;
  logic        need_gt_decl_q;

  logic [33:0] w3;
  logic [33:0] stride_raw;
  logic        sizes_bad;

  assign evt_o.first = (count_q == '0);
  assign evt_o.last  = (count_q == HDR_CNT_W'(HDR_LEN - 1));
  assign count_d     = evt_o.last ? '0 : count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (byte_valid_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      if (count_q == HDR_CNT_W'(OFS_SIG)) sig0_q <= byte_i;
      if (count_q == HDR_CNT_W'(OFS_SIG + 1)) sig1_q <= byte_i;
      for (int k = 0; k < 4; k++) begin
        if (count_q == HDR_CNT_W'(OFS_DECL + k))   decl_q[8*k +: 8]   <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_OFFSET + k)) offset_q[8*k +: 8] <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_DIB + k))    dib_q[8*k +: 8]    <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_WIDTH + k))  width_q[8*k +: 8]  <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_HEIGHT + k)) height_q[8*k +: 8] <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_COMP + k))   comp_q[8*k +: 8]   <= byte_i;
      end
      for (int k = 0; k < 2; k++) begin
        if (count_q == HDR_CNT_W'(OFS_PLANES + k)) planes_q[8*k +: 8] <= byte_i;
        if (count_q == HDR_CNT_W'(OFS_DEPTH + k))  depth_q[8*k +: 8]  <= byte_i;
      end
    end
  end

  assign w3         = {2'b00, width_q} + {1'b0, width_q, 1'b0};
  assign stride_raw = w3 + 34'd3;

  always_ff @(posedge clk_i) begin
    hdr_end_q    <= 33'(FILE_HDR_LEN) + {1'b0, dib_q};
    stride_q     <= {stride_raw[33:2], 2'b00};
    abs_h_q      <= height_q[31] ? (~height_q + 32'd1) : height_q;
    sig_bad_q    <= (sig0_q != SIG_B) || (sig1_q != SIG_M);
    decl_short_q <= decl_q < 32'(HDR_LEN);
    dib_short_q  <= dib_q < 32'(INFO_HDR_LEN);
    geo_bad_q    <= (width_q == '0) || width_q[31] || (height_q == '0) ||
                    (height_q == HEIGHT_MIN);
    fmt_bad_q    <= (planes_q != PLANES_OK) || (depth_q != DEPTH_24) ||
                    (comp_q != COMP_NONE);

    end_bad_q      <= (hdr_end_q > {1'b0, decl_q}) || ({1'b0, offset_q} < hdr_end_q) ||
                      (offset_q > decl_q);
    stride_ovf_q   <= (stride_q[33:32] != 2'b00);
    prod_q         <= 64'(stride_q[31:0]) * 64'(abs_h_q);
    need_q         <= 65'(offset_q) + 65'(prod_q);
    need_gt_decl_q <= need_q > 65'(decl_q);
  end

  assign sizes_bad = decl_short_q || (decl_q > buffer_size_i) || dib_short_q ||
                     end_bad_q || geo_bad_q;

  always_comb begin
    priority if (buffer_size_i < 32'(HDR_LEN)) begin
      res_o.status = ST_BUF_SHORT;
    end else if (sig_bad_q) begin
      res_o.status = ST_BAD_SIG;
    end else if (sizes_bad) begin
      res_o.status = ST_BAD_SIZES;
    end else if (fmt_bad_q) begin
      res_o.status = ST_UNSUPPORTED;
    end else if (stride_ovf_q) begin
      res_o.status = ST_STRIDE_OVF;
    end else if (need_gt_decl_q || (need_q > 65'(buffer_size_i))) begin
      res_o.status = ST_PIX_EXCEED;
    end else begin
      res_o.status = ST_OK;
    end
  end

  assign res_o.geom.width     = width_q[30:0];
  assign res_o.geom.height    = abs_h_q[30:0];
  assign res_o.geom.start     = offset_q;
  assign res_o.geom.stride    = stride_q[31:0];
  assign res_o.geom.top_first = height_q[31];
  assign res_o.file_size      = decl_q;

endmodule
